### hdl/mfls_pkg.sv
package mfls_pkg;

   localparam int LANES_DEFAULT       = 4;
   localparam int LEVELS_DEFAULT      = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // lanes that have bits in the request
   localparam int IN_LANES = 4;
   localparam int OUT_LANES_MAX = 4;

   localparam int ACTION_W  = 3;
   localparam int LANE_IN_W = 2;
   localparam int NOW_W     = 32;
   localparam int MASK_W    = IN_LANES;
   localparam int WAIT_W    = 16;
   localparam int TOTAL_W   = 16;
   localparam int RUN_W     = 8;
   localparam int DRL_W     = 7;
   localparam int QUANTUM_W = 8;
   localparam int LEVELS_W  = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [RUN_W-1:0] RUN_MAX = '1;

   localparam int LOAD_HIGH = 5;
   localparam int LOAD_LOW  = 2;

   localparam logic [WAIT_W-1:0]    PROMO_WAIT_RESET = 16'd10;
   localparam logic [DRL_W-1:0]     DEMO_RUN_RESET   = 7'd5;
   localparam logic [WAIT_W-1:0]    AGING_RESET      = 16'd15;
   localparam logic [QUANTUM_W-1:0] QUANTUM_H_RESET  = 8'd2;
   localparam logic [QUANTUM_W-1:0] QUANTUM_M_RESET  = 8'd4;
   localparam logic [QUANTUM_W-1:0] QUANTUM_L_RESET  = 8'd6;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SCHEDULE     = 3'd0,
      ACT_ADAPTIVE     = 3'd1,
      ACT_PROMOTE      = 3'd2,
      ACT_DEMOTE       = 3'd3,
      ACT_RESET_LEVELS = 3'd4
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROMO_WAIT = 3'd0,
      CSR_DEMO_RUN   = 3'd1,
      CSR_AGING      = 3'd2,
      CSR_QUANTUM_H  = 3'd3,
      CSR_QUANTUM_M  = 3'd4,
      CSR_QUANTUM_L  = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_SCHEDULE,
      OP_ADAPTIVE,
      OP_PROMOTE,
      OP_DEMOTE,
      OP_SETUP,
      OP_NONE
   } op_kind_type;

   typedef struct packed {
      logic [WAIT_W-1:0]    promotion_wait_limit;
      logic [DRL_W-1:0]     demotion_run_limit;
      logic [WAIT_W-1:0]    aging_limit;
      logic [QUANTUM_W-1:0] quantum_high;
      logic [QUANTUM_W-1:0] quantum_medium;
      logic [QUANTUM_W-1:0] quantum_low;
   } cfg_type;

   typedef struct packed {
      op_kind_type                      kind;
      logic [LANE_IN_W-1:0]             lane;
      logic [NOW_W-1:0]                 now;
      logic [IN_LANES-1:0]              elig_mask;
      logic [IN_LANES-1:0]              running_mask;
      logic [IN_LANES-1:0][WAIT_W-1:0]  waits;
      logic [WAIT_W-1:0]                pthr;
      logic [RUN_W-1:0]                 dthr;
   } op_type;

endpackage

### hdl/mfls_if.sv
interface mfls_req_if import mfls_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [LANE_IN_W-1:0] lane;
   logic [NOW_W-1:0]     now;
   logic [MASK_W-1:0]    ready_mask;
   logic [MASK_W-1:0]    blocked_mask;
   logic [MASK_W-1:0]    running_mask;
   logic [WAIT_W-1:0]    wait_lane0;
   logic [WAIT_W-1:0]    wait_lane1;
   logic [WAIT_W-1:0]    wait_lane2;
   logic [WAIT_W-1:0]    wait_lane3;
   logic [TOTAL_W-1:0]   total_queue;

   modport source (
      output valid, action, lane, now, ready_mask, blocked_mask, running_mask,
             wait_lane0, wait_lane1, wait_lane2, wait_lane3, total_queue,
      input  ready
   );
   modport sink (
      input  valid, action, lane, now, ready_mask, blocked_mask, running_mask,
             wait_lane0, wait_lane1, wait_lane2, wait_lane3, total_queue,
      output ready
   );
endinterface

interface mfls_rsp_if import mfls_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 granted;
   logic [LANE_IN_W-1:0] chosen_lane;
   logic [QUANTUM_W-1:0] quantum;
   logic [LEVELS_W-1:0]  lane_levels;

   modport source (
      output valid, granted, chosen_lane, quantum, lane_levels,
      input  ready
   );
   modport sink (
      input  valid, granted, chosen_lane, quantum, lane_levels,
      output ready
   );
endinterface

### hdl/mfls_front.sv
module mfls_front import mfls_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   mfls_req_if.sink               req_chan,
   input  logic                   queue_full,
   output logic                   queue_push,
   output op_type                 op,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   logic [2:0]         nready;
   logic [4:0]         high_bound;
   logic [4:0]         low_bound;
   logic               load_high;
   logic               load_not_low;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.promotion_wait_limit <= PROMO_WAIT_RESET;
         cfg_ff.demotion_run_limit   <= DEMO_RUN_RESET;
         cfg_ff.aging_limit          <= AGING_RESET;
         cfg_ff.quantum_high         <= QUANTUM_H_RESET;
         cfg_ff.quantum_medium       <= QUANTUM_M_RESET;
         cfg_ff.quantum_low          <= QUANTUM_L_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROMO_WAIT: cfg_in.promotion_wait_limit = csr_wr_data;
            CSR_DEMO_RUN:   cfg_in.demotion_run_limit   = csr_wr_data[DRL_W-1:0];
            CSR_AGING:      cfg_in.aging_limit          = csr_wr_data;
            CSR_QUANTUM_H:  cfg_in.quantum_high         = csr_wr_data[QUANTUM_W-1:0];
            CSR_QUANTUM_M:  cfg_in.quantum_medium       = csr_wr_data[QUANTUM_W-1:0];
            CSR_QUANTUM_L:  cfg_in.quantum_low          = csr_wr_data[QUANTUM_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

   // load thresholds for the adaptive transaction
   assign nready       = 3'($countones(req_chan.ready_mask));
   assign high_bound   = 5'(LOAD_HIGH) * {2'b00, nready};
   assign low_bound    = 5'(LOAD_LOW) * {2'b00, nready};
   assign load_high    = (nready != 3'd0) && (req_chan.total_queue > TOTAL_W'(high_bound));
   assign load_not_low = (nready != 3'd0) && !(req_chan.total_queue < TOTAL_W'(low_bound));

   always_comb begin
      op.lane         = req_chan.lane;
      op.now          = req_chan.now;
      op.elig_mask    = req_chan.ready_mask & ~req_chan.blocked_mask;
      op.running_mask = req_chan.running_mask;
      op.waits[0]     = req_chan.wait_lane0;
      op.waits[1]     = req_chan.wait_lane1;
      op.waits[2]     = req_chan.wait_lane2;
      op.waits[3]     = req_chan.wait_lane3;
      op.pthr         = load_high ? (cfg_ff.promotion_wait_limit >> 1)
                                  : cfg_ff.promotion_wait_limit;
      op.dthr         = load_not_low ? {1'b0, cfg_ff.demotion_run_limit}
                                     : {cfg_ff.demotion_run_limit, 1'b0};
      unique case (action_type'(req_chan.action))
         ACT_SCHEDULE:     op.kind = OP_SCHEDULE;
         ACT_ADAPTIVE:     op.kind = OP_ADAPTIVE;
         ACT_PROMOTE:      op.kind = OP_PROMOTE;
         ACT_DEMOTE:       op.kind = OP_DEMOTE;
         ACT_RESET_LEVELS: op.kind = OP_SETUP;
         default:          op.kind = OP_NONE;
      endcase
   end

   assign req_chan.ready = !queue_full;
   assign queue_push     = req_chan.valid && !queue_full;

endmodule

### hdl/mfls_fifo.sv
module mfls_fifo import mfls_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_data,
   output logic   full,
   input  logic   pop,
   output op_type pop_data,
   output logic   not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   op_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

endmodule

### hdl/mfls_back.sv
module mfls_back import mfls_pkg::*; #(
   parameter int LANES  = LANES_DEFAULT,
   parameter int LEVELS = LEVELS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  op_type     op,
   input  logic       op_valid,
   output logic       op_pop,
   mfls_rsp_if.source rsp_chan
);

   localparam int LVL_W     = $clog2(LEVELS);
   localparam int LANE_W    = $clog2(LANES);
   localparam int OUT_LANES = (LANES < OUT_LANES_MAX) ? LANES : OUT_LANES_MAX;
   localparam logic [LVL_W-1:0] LVL_TOP = '0;
   localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);
   localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);

   logic [LVL_W-1:0]  level_ff [LANES];
   logic [LVL_W-1:0]  level_in [LANES];
   logic [RUN_W-1:0]  run_ff   [LANES];
   logic [RUN_W-1:0]  run_in   [LANES];
   logic [NOW_W-1:0]  promoted_ff [LANES];
   logic [NOW_W-1:0]  promoted_in [LANES];
   logic              started_ff, started_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 granted_ff, granted_in;
   logic [LANE_IN_W-1:0] chosen_ff, chosen_in;
   logic [QUANTUM_W-1:0] quantum_ff, quantum_in;
   logic [LEVELS_W-1:0]  levels_ff, levels_in;

   logic [WAIT_W-1:0] lane_wait [LANES];
   logic [LANES-1:0]  lane_elig;
   logic [LANES-1:0]  lane_run;

   logic is_sched;

   // lanes beyond the request fields are never ready or running
   for (genvar g = 0; g < LANES; g++) begin : g_lane_in
      if (g < IN_LANES) begin : g_real
         assign lane_wait[g] = op.waits[g];
         assign lane_elig[g] = op.elig_mask[g];
         assign lane_run[g]  = op.running_mask[g];
      end else begin : g_pad
         assign lane_wait[g] = '0;
         assign lane_elig[g] = 1'b0;
         assign lane_run[g]  = 1'b0;
      end
   end

   assign is_sched = (op.kind == OP_SCHEDULE) || (op.kind == OP_ADAPTIVE);
   assign op_pop   = op_valid && (!rsp_valid_ff || rsp_chan.ready);

   // per-lane state update
   always_comb begin
      logic [LVL_W-1:0] lv;
      logic [RUN_W-1:0] rc;
      logic [NOW_W-1:0] pa;
      logic [NOW_W-1:0] in_level;
      started_in = started_ff;
      if (is_sched || (op.kind == OP_SETUP)) begin
         started_in = 1'b1;
      end
      for (int i = 0; i < LANES; i++) begin
         lv = level_ff[i];
         rc = run_ff[i];
         pa = promoted_ff[i];
         in_level = '0;
         case (op.kind)
            OP_SCHEDULE, OP_ADAPTIVE: begin
               if (!started_ff) begin
                  lv = LVL_ONE;
                  rc = '0;
                  pa = op.now;
               end
               if (op.kind == OP_ADAPTIVE) begin
                  if (lane_wait[i] > op.pthr && lv != LVL_TOP) begin
                     lv = lv - LVL_ONE;
                     pa = op.now;
                     rc = '0;
                  end
                  if (rc > op.dthr && lv != LVL_MAX) begin
                     lv = lv + LVL_ONE;
                     rc = '0;
                  end
               end
               in_level = op.now - pa;
               if (lane_wait[i] > cfg.promotion_wait_limit && lv != LVL_TOP) begin
                  lv = lv - LVL_ONE;
                  pa = op.now;
                  rc = '0;
               end
               if (in_level > NOW_W'(cfg.aging_limit) && lv != LVL_TOP) begin
                  lv = LVL_TOP;
                  pa = op.now;
                  rc = '0;
               end
               if (lane_run[i]) begin
                  if (rc != RUN_MAX) begin
                     rc = rc + RUN_W'(1);
                  end
                  if (rc > {1'b0, cfg.demotion_run_limit} && lv != LVL_MAX) begin
                     lv = lv + LVL_ONE;
                     rc = '0;
                  end
               end else begin
                  rc = '0;
               end
            end
            OP_PROMOTE: begin
               if (started_ff && int'(op.lane) == i && lv != LVL_TOP) begin
                  lv = lv - LVL_ONE;
                  pa = op.now;
                  rc = '0;
               end
            end
            OP_DEMOTE: begin
               if (started_ff && int'(op.lane) == i && lv != LVL_MAX) begin
                  lv = lv + LVL_ONE;
                  rc = '0;
               end
            end
            OP_SETUP: begin
               lv = LVL_ONE;
               rc = '0;
               pa = op.now;
            end
            default: ;
         endcase
         level_in[i]    = lv;
         run_in[i]      = rc;
         promoted_in[i] = pa;
      end
   end

   // grant: best level, then longest wait, lower index on a tie
   always_comb begin
      logic                 found;
      logic [LANE_W-1:0]    best_idx;
      logic [LVL_W-1:0]     best_lvl;
      logic [WAIT_W-1:0]    best_wait;
      logic [LANE_W+1:0]    idx_ext;
      logic [LVL_W+1:0]     lvl_ext;
      found     = 1'b0;
      best_idx  = '0;
      best_lvl  = '0;
      best_wait = '0;
      for (int i = 0; i < LANES; i++) begin
         if (lane_elig[i] && (!found || level_in[i] < best_lvl ||
             (level_in[i] == best_lvl && lane_wait[i] > best_wait))) begin
            found     = 1'b1;
            best_idx  = LANE_W'(i);
            best_lvl  = level_in[i];
            best_wait = lane_wait[i];
         end
      end
      idx_ext    = {2'b00, best_idx};
      granted_in = is_sched && found;
      chosen_in  = granted_in ? idx_ext[1:0] : '0;
      if (!granted_in) begin
         quantum_in = '0;
      end else if (best_lvl == LVL_TOP) begin
         quantum_in = cfg.quantum_high;
      end else if (best_lvl == LVL_ONE) begin
         quantum_in = cfg.quantum_medium;
      end else begin
         quantum_in = cfg.quantum_low;
      end
      levels_in = '0;
      for (int i = 0; i < OUT_LANES; i++) begin
         lvl_ext = {2'b00, level_in[i]};
         levels_in[2*i +: 2] = lvl_ext[1:0];
      end
   end

   always_comb begin
      if (op_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            level_ff[i]    <= LVL_ONE;
            run_ff[i]      <= '0;
            promoted_ff[i] <= '0;
         end
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (op_pop) begin
            level_ff    <= level_in;
            run_ff      <= run_in;
            promoted_ff <= promoted_in;
            started_ff  <= started_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         granted_ff <= granted_in;
         chosen_ff  <= chosen_in;
         quantum_ff <= quantum_in;
         levels_ff  <= levels_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.granted     = granted_ff;
   assign rsp_chan.chosen_lane = chosen_ff;
   assign rsp_chan.quantum     = quantum_ff;
   assign rsp_chan.lane_levels = levels_ff;

endmodule

### hdl/multilevel_feedback_lane_scheduler.sv
// response path: an accepted request is written into the queue; the back end
//   pops it and registers its response in the output register on rsp_chan
// throughput: one transaction per cycle unless rsp_chan or the queue stalls;
//   lane state update and grant select in the back end are combinational
// reset (synchronous, active high): registers back to defaults, lanes at
//   medium level, queue and output register empty; no clearing pass
module multilevel_feedback_lane_scheduler import mfls_pkg::*; #(
   parameter int LANES       = LANES_DEFAULT,
   parameter int LEVELS      = LEVELS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   mfls_req_if.sink               req_chan,
   mfls_rsp_if.source             rsp_chan
);

   op_type  front_op;
   op_type  back_op;
   cfg_type cfg;
   logic    queue_full;
   logic    queue_push;
   logic    queue_pop;
   logic    queue_not_empty;

   mfls_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .op          (front_op),
      .cfg         (cfg)
   );

   mfls_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (front_op),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (back_op),
      .not_empty (queue_not_empty)
   );

   mfls_back #(
      .LANES  (LANES),
      .LEVELS (LEVELS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .op       (back_op),
      .op_valid (queue_not_empty),
      .op_pop   (queue_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### hdl/mfls_checker.sv
module mfls_checker import mfls_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_granted,
   input logic [LANE_IN_W-1:0] rsp_chosen_lane,
   input logic [QUANTUM_W-1:0] rsp_quantum,
   input logic [LEVELS_W-1:0]  rsp_lane_levels
);

   // a response without a grant carries no lane and no quantum
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_chosen_lane == '0 && rsp_quantum == '0)
      else $error("ungranted response with nonzero lane or quantum");

   // output register empties on reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // queue is empty after reset and takes a transaction
   assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready right after reset");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted) &&
         $stable(rsp_chosen_lane) && $stable(rsp_quantum) && $stable(rsp_lane_levels))
      else $error("stalled response changed");

endmodule

bind multilevel_feedback_lane_scheduler mfls_checker u_mfls_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_granted     (rsp_chan.granted),
   .rsp_chosen_lane (rsp_chan.chosen_lane),
   .rsp_quantum     (rsp_chan.quantum),
   .rsp_lane_levels (rsp_chan.lane_levels)
);

### test/tb_multilevel_feedback_lane_scheduler.sv
module tb_multilevel_feedback_lane_scheduler;
   import mfls_pkg::*;

   localparam int LOWEST_LEVEL = LEVELS_DEFAULT - 1;
   localparam int RANDOM_PER_PHASE = 125;
   localparam int PHASES = 6;
   localparam logic [ACTION_W-1:0] ACT_UNDEFINED_FIRST = 3'(ACT_RESET_LEVELS) + 3'd1;

   typedef struct packed {
      logic [ACTION_W-1:0]             action;
      logic [LANE_IN_W-1:0]            lane;
      logic [NOW_W-1:0]                now;
      logic [MASK_W-1:0]               ready_mask;
      logic [MASK_W-1:0]               blocked_mask;
      logic [MASK_W-1:0]               running_mask;
      logic [IN_LANES-1:0][WAIT_W-1:0] waits;
      logic [TOTAL_W-1:0]              total;
   } sched_req_type;

   typedef struct packed {
      logic                 granted;
      logic [LANE_IN_W-1:0] chosen_lane;
      logic [QUANTUM_W-1:0] quantum;
      logic [LEVELS_W-1:0]  lane_levels;
   } grant_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   mfls_req_if req_chan ();
   mfls_rsp_if rsp_chan ();

   multilevel_feedback_lane_scheduler dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   always #1 clock = ~clock;

   // shadow of the scheduler's registers and lane state
   logic [WAIT_W-1:0]    cfg_promo_wait = PROMO_WAIT_RESET;
   logic [DRL_W-1:0]     cfg_demo_run   = DEMO_RUN_RESET;
   logic [WAIT_W-1:0]    cfg_aging      = AGING_RESET;
   logic [QUANTUM_W-1:0] cfg_q_high     = QUANTUM_H_RESET;
   logic [QUANTUM_W-1:0] cfg_q_medium   = QUANTUM_M_RESET;
   logic [QUANTUM_W-1:0] cfg_q_low      = QUANTUM_L_RESET;

   logic [1:0]       lane_lvl [IN_LANES];
   logic [RUN_W-1:0] lane_runs [IN_LANES];
   logic [NOW_W-1:0] lane_promoted_at [IN_LANES];
   logic             lanes_set_up = 1'b0;

   sched_req_type requests_pending [$];
   grant_type     grants_due [$];
   sched_req_type on_bus;
   grant_type     got_grant;
   grant_type     want_grant;
   int            failures = 0;
   int            send_idle_pct = 21;
   int            recv_idle_pct = 55;

   logic [NOW_W-1:0]  gen_now = '0;
   logic [MASK_W-1:0] gen_running = '0;

   initial begin
      for (int i = 0; i < IN_LANES; i++) begin
         lane_lvl[i] = 2'd1;
         lane_runs[i] = '0;
         lane_promoted_at[i] = '0;
      end
   end

   function automatic void setup_lanes(logic [NOW_W-1:0] t);
      for (int i = 0; i < IN_LANES; i++) begin
         lane_lvl[i] = 2'd1;
         lane_runs[i] = '0;
         lane_promoted_at[i] = t;
      end
      lanes_set_up = 1'b1;
   endfunction

   function automatic void raise_lane(int i, logic [NOW_W-1:0] t);
      if (lane_lvl[i] > 0) begin
         lane_lvl[i] = lane_lvl[i] - 2'd1;
         lane_promoted_at[i] = t;
         lane_runs[i] = '0;
      end
   endfunction

   function automatic void lower_lane(int i);
      if (int'(lane_lvl[i]) < LOWEST_LEVEL) begin
         lane_lvl[i] = lane_lvl[i] + 2'd1;
         lane_runs[i] = '0;
      end
   endfunction

   function automatic grant_type predict_grant(sched_req_type it);
      grant_type        g;
      int               best;
      logic [1:0]       best_lvl;
      logic [WAIT_W-1:0] best_wait;
      int               nready;
      int               pthr;
      int               dthr;
      logic [NOW_W-1:0] in_lvl;
      g = '0;
      best = -1;
      best_lvl = '0;
      best_wait = '0;
      if (it.action == ACT_SCHEDULE || it.action == ACT_ADAPTIVE) begin
         if (!lanes_set_up) setup_lanes(it.now);
         if (it.action == ACT_ADAPTIVE) begin
            nready = $countones(it.ready_mask);
            pthr = int'(cfg_promo_wait);
            dthr = 2 * int'(cfg_demo_run);
            if (nready > 0) begin
               if (int'(it.total) > LOAD_HIGH * nready) pthr = int'(cfg_promo_wait) / 2;
               if (!(int'(it.total) < LOAD_LOW * nready)) dthr = int'(cfg_demo_run);
            end
            for (int i = 0; i < IN_LANES; i++) begin
               if (int'(it.waits[i]) > pthr) raise_lane(i, it.now);
               if (int'(lane_runs[i]) > dthr) lower_lane(i);
            end
         end
         for (int i = 0; i < IN_LANES; i++) begin
            in_lvl = it.now - lane_promoted_at[i];
            if (it.waits[i] > cfg_promo_wait) raise_lane(i, it.now);
            if (in_lvl > NOW_W'(cfg_aging) && lane_lvl[i] > 0) begin
               lane_lvl[i] = 2'd0;
               lane_promoted_at[i] = it.now;
               lane_runs[i] = '0;
            end
            if (it.running_mask[i]) begin
               if (lane_runs[i] != RUN_MAX) lane_runs[i] = lane_runs[i] + 1'b1;
               if (int'(lane_runs[i]) > int'(cfg_demo_run)) lower_lane(i);
            end else begin
               lane_runs[i] = '0;
            end
         end
         for (int i = 0; i < IN_LANES; i++) begin
            if (!it.ready_mask[i] || it.blocked_mask[i]) continue;
            if (best < 0 || lane_lvl[i] < best_lvl ||
                (lane_lvl[i] == best_lvl && it.waits[i] > best_wait)) begin
               best = i;
               best_lvl = lane_lvl[i];
               best_wait = it.waits[i];
            end
         end
         if (best >= 0) begin
            g.granted = 1'b1;
            g.chosen_lane = LANE_IN_W'(best);
            g.quantum = (best_lvl == 2'd0) ? cfg_q_high :
                        (best_lvl == 2'd1) ? cfg_q_medium : cfg_q_low;
         end
      end else if (it.action == ACT_PROMOTE || it.action == ACT_DEMOTE) begin
         if (lanes_set_up) begin
            if (it.action == ACT_PROMOTE) raise_lane(int'(it.lane), it.now);
            else lower_lane(int'(it.lane));
         end
      end else if (it.action == ACT_RESET_LEVELS) begin
         setup_lanes(it.now);
      end
      for (int i = 0; i < IN_LANES; i++) g.lane_levels[2*i +: 2] = lane_lvl[i];
      return g;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) grants_due.push_back(predict_grant(on_bus));
         if (!req_chan.valid || req_chan.ready) begin
            if (requests_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               on_bus = requests_pending.pop_front();
               req_chan.valid        <= 1'b1;
               req_chan.action       <= on_bus.action;
               req_chan.lane         <= on_bus.lane;
               req_chan.now          <= on_bus.now;
               req_chan.ready_mask   <= on_bus.ready_mask;
               req_chan.blocked_mask <= on_bus.blocked_mask;
               req_chan.running_mask <= on_bus.running_mask;
               req_chan.wait_lane0   <= on_bus.waits[0];
               req_chan.wait_lane1   <= on_bus.waits[1];
               req_chan.wait_lane2   <= on_bus.waits[2];
               req_chan.wait_lane3   <= on_bus.waits[3];
               req_chan.total_queue  <= on_bus.total;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_grant = {rsp_chan.granted, rsp_chan.chosen_lane, rsp_chan.quantum,
                         rsp_chan.lane_levels};
            if (grants_due.size() == 0) begin
               $error("response transaction with no request outstanding");
               failures++;
            end else begin
               want_grant = grants_due.pop_front();
               if (got_grant.granted !== want_grant.granted) begin
                  $error("granted: expected %0d, got %0d", want_grant.granted, got_grant.granted);
                  failures++;
               end
               if (got_grant.chosen_lane !== want_grant.chosen_lane) begin
                  $error("chosen_lane: expected %0d, got %0d",
                         want_grant.chosen_lane, got_grant.chosen_lane);
                  failures++;
               end
               if (got_grant.quantum !== want_grant.quantum) begin
                  $error("quantum: expected %0d, got %0d", want_grant.quantum, got_grant.quantum);
                  failures++;
               end
               if (got_grant.lane_levels !== want_grant.lane_levels) begin
                  $error("lane_levels: expected %h, got %h",
                         want_grant.lane_levels, got_grant.lane_levels);
                  failures++;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic sched_req_type make_req(logic [ACTION_W-1:0] act,
                                              logic [LANE_IN_W-1:0] ln,
                                              logic [NOW_W-1:0] t, logic [MASK_W-1:0] rdy,
                                              logic [MASK_W-1:0] blk, logic [MASK_W-1:0] run,
                                              logic [WAIT_W-1:0] w0, logic [WAIT_W-1:0] w1,
                                              logic [WAIT_W-1:0] w2, logic [WAIT_W-1:0] w3,
                                              logic [TOTAL_W-1:0] tq);
      sched_req_type it;
      it.action = act;
      it.lane = ln;
      it.now = t;
      it.ready_mask = rdy;
      it.blocked_mask = blk;
      it.running_mask = run;
      it.waits[0] = w0;
      it.waits[1] = w1;
      it.waits[2] = w2;
      it.waits[3] = w3;
      it.total = tq;
      return it;
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_PROMO_WAIT: cfg_promo_wait = val;
         CSR_DEMO_RUN:   cfg_demo_run   = val[DRL_W-1:0];
         CSR_AGING:      cfg_aging      = val;
         CSR_QUANTUM_H:  cfg_q_high     = val[QUANTUM_W-1:0];
         CSR_QUANTUM_M:  cfg_q_medium   = val[QUANTUM_W-1:0];
         CSR_QUANTUM_L:  cfg_q_low      = val[QUANTUM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int promo, input int demo, input int aging,
                                 input int qh, input int qm, input int ql);
      write_csr(CSR_PROMO_WAIT, CSR_DATA_W'(promo));
      write_csr(CSR_DEMO_RUN, CSR_DATA_W'(demo));
      write_csr(CSR_AGING, CSR_DATA_W'(aging));
      write_csr(CSR_QUANTUM_H, CSR_DATA_W'(qh));
      write_csr(CSR_QUANTUM_M, CSR_DATA_W'(qm));
      write_csr(CSR_QUANTUM_L, CSR_DATA_W'(ql));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      while (requests_pending.size() != 0 || req_chan.valid || grants_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly schedule streams with slowly advancing time and sticky running lanes
   task automatic queue_random_burst(input int count);
      sched_req_type it;
      int pick;
      int wspan;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) it.action = ACT_SCHEDULE;
         else if (pick < 75) it.action = ACT_ADAPTIVE;
         else if (pick < 84) it.action = ACT_PROMOTE;
         else if (pick < 93) it.action = ACT_DEMOTE;
         else if (pick < 98) it.action = ACT_RESET_LEVELS;
         else it.action = ACT_UNDEFINED_FIRST + ACTION_W'($urandom_range(0, 2));
         if ($urandom_range(0, 49) == 0) gen_now = $urandom;
         else gen_now = gen_now + NOW_W'($urandom_range(0, 4));
         if ($urandom_range(0, 7) == 0) gen_running = MASK_W'($urandom_range(0, 15));
         wspan = int'(cfg_promo_wait) + 3;
         if (wspan > 65535) wspan = 65535;
         it.lane = LANE_IN_W'($urandom_range(0, 3));
         it.now = gen_now;
         it.ready_mask = MASK_W'($urandom_range(0, 15));
         it.blocked_mask = MASK_W'($urandom_range(0, 15) & $urandom_range(0, 15));
         it.running_mask = gen_running;
         for (int i = 0; i < IN_LANES; i++)
            it.waits[i] = ($urandom_range(0, 15) == 0) ? WAIT_W'($urandom_range(0, 65535))
                                                      : WAIT_W'($urandom_range(0, wspan));
         it.total = ($urandom_range(0, 3) == 0) ? TOTAL_W'($urandom_range(0, 65535))
                                                : TOTAL_W'($urandom_range(0, 24));
         requests_pending.push_back(it);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.action = '0;
      req_chan.lane = '0;
      req_chan.now = '0;
      req_chan.ready_mask = '0;
      req_chan.blocked_mask = '0;
      req_chan.running_mask = '0;
      req_chan.wait_lane0 = '0;
      req_chan.wait_lane1 = '0;
      req_chan.wait_lane2 = '0;
      req_chan.wait_lane3 = '0;
      req_chan.total_queue = '0;
      rsp_chan.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // promote and demote are dropped before the first schedule
      requests_pending.push_back(make_req(ACT_PROMOTE, 2'd1, 32'd0, 4'h0, 4'h0, 4'h0,
                                          16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      requests_pending.push_back(make_req(ACT_DEMOTE, 2'd2, 32'hFFFF_FFFF, 4'hF, 4'hF, 4'hF,
                                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      // first schedule-type request is adaptive with no ready lane
      requests_pending.push_back(make_req(ACT_ADAPTIVE, 2'd0, 32'd100, 4'h0, 4'h0, 4'h0,
                                          16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      // equal waits tie to the lowest index
      requests_pending.push_back(make_req(ACT_SCHEDULE, 2'd0, 32'd100, 4'hF, 4'h0, 4'h0,
                                          16'd5, 16'd5, 16'd5, 16'd5, 16'd0));
      requests_pending.push_back(make_req(ACT_SCHEDULE, 2'd0, 32'd101, 4'hF, 4'h1, 4'h0,
                                          16'd3, 16'd7, 16'd7, 16'd2, 16'd0));
      requests_pending.push_back(make_req(ACT_SCHEDULE, 2'd0, 32'd102, 4'hF, 4'h0, 4'h0,
                                          16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0));
      // everything blocked, nothing granted
      requests_pending.push_back(make_req(ACT_SCHEDULE, 2'd0, 32'd102, 4'hF, 4'hF, 4'h0,
                                          16'd1, 16'd1, 16'd1, 16'd1, 16'd0));
      // promote past the top and demote past the bottom
      repeat (2) requests_pending.push_back(make_req(ACT_PROMOTE, 2'd0, 32'd103, 4'h0, 4'h0,
                                                     4'h0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      repeat (3) requests_pending.push_back(make_req(ACT_DEMOTE, 2'd2, 32'd103, 4'h0, 4'h0,
                                                     4'h0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      // long time in level ages lanes to the top
      requests_pending.push_back(make_req(ACT_SCHEDULE, 2'd0, 32'd120, 4'hF, 4'h0, 4'h0,
                                          16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      // lane 1 keeps running until the run count demotes it
      repeat (6) requests_pending.push_back(make_req(ACT_SCHEDULE, 2'd0, 32'd121, 4'h2, 4'h0,
                                                     4'h2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      // heavy load halves the promotion threshold
      requests_pending.push_back(make_req(ACT_ADAPTIVE, 2'd0, 32'd122, 4'hF, 4'h0, 4'h0,
                                          16'd6, 16'd6, 16'd6, 16'd6, 16'hFFFF));
      // light load doubles the demotion threshold
      requests_pending.push_back(make_req(ACT_ADAPTIVE, 2'd0, 32'd122, 4'h1, 4'h0, 4'hF,
                                          16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      requests_pending.push_back(make_req(ACT_RESET_LEVELS, 2'd3, 32'hFFFF_FFFF, 4'h0, 4'h0,
                                          4'h0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      // time wraps around zero
      requests_pending.push_back(make_req(ACT_SCHEDULE, 2'd0, 32'd0, 4'hF, 4'h0, 4'h0,
                                          16'd4, 16'd3, 16'd2, 16'd1, 16'd0));
      requests_pending.push_back(make_req(ACT_UNDEFINED_FIRST, 2'd3, 32'hFFFF_FFFF, 4'hF,
                                          4'h0, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF));
      requests_pending.push_back(make_req(ACT_UNDEFINED_FIRST + 3'd2, 2'd1, 32'd5, 4'h0,
                                          4'h0, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      gen_now = 32'd10;

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         if (phase < 2) begin
            send_idle_pct = 21;
            recv_idle_pct = 55;
         end else if (phase < 4) begin
            send_idle_pct = 55;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            1: begin
               apply_settings(65535, 127, 65535, 255, 255, 255);
               gen_now = 32'hFFFF_FFC0;
            end
            2: apply_settings(0, 0, 0, 0, 0, 0);
            3: apply_settings($urandom_range(2, 30), $urandom_range(1, 8),
                              $urandom_range(5, 60), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255));
            4: begin
               apply_settings($urandom_range(0, 65535), $urandom_range(0, 127),
                              $urandom_range(0, 65535), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255));
               gen_now = $urandom;
            end
            5: apply_settings(4, 2, 25, $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255));
            default: ;
         endcase
         queue_random_burst(RANDOM_PER_PHASE);
      end
      drain();

      if (failures == 0 && grants_due.size() == 0) begin
         $display("multilevel_feedback_lane_scheduler verification clean");
      end else begin
         $display("multilevel_feedback_lane_scheduler verification failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("multilevel_feedback_lane_scheduler verification failed");
      $finish;
   end

endmodule
